// ===== hw/rtl/tct_pkg.sv =====
// shared types and constants for the text cell terminal
package tct_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // configuration register indexes
    localparam logic [1:0] CFG_COLUMNS   = 2'd0;
    localparam logic [1:0] CFG_ROWS_USED = 2'd1;
    localparam logic [1:0] CFG_ON_SCREEN = 2'd2;

    localparam logic [7:0] COLUMNS_RST   = 8'd128;
    localparam logic [6:0] ROWS_USED_RST = 7'd48;
    localparam logic       ON_SCREEN_RST = 1'b1;

    typedef enum logic [1:0] {
        KIND_CURSOR = 2'd0,
        KIND_CELL   = 2'd1,
        KIND_SCROLL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_PUT = 2'd0,
        OP_CR  = 2'd1,
        OP_LF  = 2'd2,
        OP_BS  = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
    } t_qent;

    typedef struct packed {
        logic [7:0] columns;
        logic [6:0] rows_used;
        logic       on_screen;
    } t_cfg;

endpackage

// ===== hw/rtl/tct_front.sv =====
// front end: accepts character bytes, decodes them and queues them for the back end
module tct_front import tct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_ch,
    output logic       o_ready,
    input  logic       i_hold,
    output logic       o_q_valid,
    output t_qent      o_q_ent,
    input  logic       i_q_pop
);

    t_qent      r_ent [2];
    logic       r_rd_ptr;
    logic       r_wr_ptr;
    logic [1:0] r_count;
    logic       push;
    t_qent      n_ent;

    always_comb begin
        n_ent.ch = i_ch;
        case (i_ch)
            CH_CR:   n_ent.op = OP_CR;
            CH_LF:   n_ent.op = OP_LF;
            CH_BS:   n_ent.op = OP_BS;
            default: n_ent.op = OP_PUT;
        endcase
    end

    assign o_ready   = (r_count != 2'd2) && !i_hold;
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_ent   = r_ent[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, i_q_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr_ptr] <= n_ent;
        end
    end

endmodule

// ===== hw/rtl/tct_back.sv =====
// back end: cursor, screen store with row ring, scroll blanking and result register
module tct_back import tct_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_qent      i_q_ent,
    output logic       o_q_pop,
    output logic       o_clearing,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [6:0] o_col,
    output logic [5:0] o_row,
    output logic [7:0] o_cell_char,
    output logic [6:0] o_cursor_col,
    output logic [5:0] o_cursor_row,
    output logic       o_last
);

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NCW   = $clog2(MAX_COLS + 1);
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EMIT,
        S_BLANK
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr;
    logic [CW-1:0]   r_bcol;
    logic [RW-1:0]   r_top;
    logic [CW-1:0]   r_cur_col;
    logic [RW-1:0]   r_cur_row;

    // step results held between decode and emit
    t_kind           r_kind;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic            r_is_cell;
    logic            r_last;
    logic            r_two;
    logic            r_scroll;
    logic [AW-1:0]   r_addr;
    logic            r_pend2;

    logic            r_out_valid;
    t_kind           r_out_kind;
    logic [CW-1:0]   r_out_col;
    logic [RW-1:0]   r_out_row;
    logic            r_out_is_cell;
    logic [CW-1:0]   r_out_ccol;
    logic [RW-1:0]   r_out_crow;
    logic            r_out_last;

    logic [7:0]      r_mem [DEPTH];
    logic [7:0]      r_rd_data;

    logic [NCW-1:0]  nc;
    logic [NRW-1:0]  nr;
    logic [CW-1:0]   last_c;
    logic [RW-1:0]   last_r;
    logic [CW-1:0]   cc;
    logic [RW-1:0]   cr;
    logic [CW-1:0]   n_col;
    logic [RW-1:0]   n_row;
    logic [CW-1:0]   w_col;
    logic            s_write;
    logic            s_newline;
    logic            s_scroll;
    logic            s_show_cell;
    logic            s_two;
    t_kind           s_kind;
    logic [7:0]      s_char;
    logic            slot_free;
    logic            pop;
    logic            load1;
    logic            load2;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;

    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] r);
        logic [RW:0] s;
        s = {1'b0, top} + {1'b0, r};
        if (s >= (RW+1)'(MAX_ROWS)) begin
            s = s - (RW+1)'(MAX_ROWS);
        end
        return s[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] col);
        return AW'(prow) * AW'(MAX_COLS) + AW'(col);
    endfunction

    // usable area, zero read as one and oversize saturated
    always_comb begin
        if (i_cfg.columns == 8'd0) begin
            nc = NCW'(1);
        end else if ({1'b0, i_cfg.columns} > 9'(MAX_COLS)) begin
            nc = NCW'(MAX_COLS);
        end else begin
            nc = NCW'(i_cfg.columns);
        end
        if (i_cfg.rows_used == 7'd0) begin
            nr = NRW'(1);
        end else if ({1'b0, i_cfg.rows_used} > 8'(MAX_ROWS)) begin
            nr = NRW'(MAX_ROWS);
        end else begin
            nr = NRW'(i_cfg.rows_used);
        end
    end

    assign last_c = CW'(nc - NCW'(1));
    assign last_r = RW'(nr - NRW'(1));
    assign cc     = (r_cur_col > last_c) ? last_c : r_cur_col;
    assign cr     = (r_cur_row > last_r) ? last_r : r_cur_row;

    // decode of one queued byte against the clamped cursor
    always_comb begin
        n_col     = cc;
        n_row     = cr;
        w_col     = cc;
        s_write   = 1'b0;
        s_newline = 1'b0;
        s_char    = i_q_ent.ch;
        case (i_q_ent.op)
            OP_CR: begin
                n_col = '0;
            end
            OP_LF: begin
                s_newline = 1'b1;
            end
            OP_BS: begin
                if (cc != '0) begin
                    w_col = cc - CW'(1);
                end
                n_col   = w_col;
                s_write = 1'b1;
                s_char  = CH_SPACE;
            end
            default: begin
                s_write = 1'b1;
                if (cc == last_c) begin
                    s_newline = 1'b1;
                end else begin
                    n_col = cc + CW'(1);
                end
            end
        endcase
        s_scroll = s_newline && (cr == last_r);
        if (s_newline) begin
            n_col = '0;
            n_row = s_scroll ? cr : cr + RW'(1);
        end
        s_show_cell = i_cfg.on_screen && s_write;
        s_two       = s_show_cell && s_scroll;
        if (s_show_cell) begin
            s_kind = KIND_CELL;
        end else if (i_cfg.on_screen && s_scroll) begin
            s_kind = KIND_SCROLL;
        end else begin
            s_kind = KIND_CURSOR;
        end
    end

    assign slot_free = !r_out_valid || i_ready;
    assign pop       = (r_state == S_IDLE) && i_q_valid && !r_pend2;
    assign load1     = (r_state == S_EMIT) && slot_free;
    assign load2     = (r_state != S_EMIT) && r_pend2 && slot_free;

    // one store write port shared by the clear pass, row blanking and cell writes
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cell_addr(phys_row(r_top, cr), w_col);
        wr_data = s_char;
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = CH_SPACE;
            end
            S_BLANK: begin
                wr_en   = 1'b1;
                wr_addr = cell_addr(phys_row(r_top, last_r), r_bcol);
                wr_data = CH_SPACE;
            end
            S_IDLE: begin
                wr_en = pop && s_write;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // cell reported back from the store itself
    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_bcol        <= '0;
            r_top         <= '0;
            r_cur_col     <= '0;
            r_cur_row     <= '0;
            r_pend2       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_kind        <= KIND_CURSOR;
            r_col         <= '0;
            r_row         <= '0;
            r_is_cell     <= 1'b0;
            r_last        <= 1'b1;
            r_two         <= 1'b0;
            r_scroll      <= 1'b0;
            r_addr        <= '0;
            r_out_kind    <= KIND_CURSOR;
            r_out_col     <= '0;
            r_out_row     <= '0;
            r_out_is_cell <= 1'b0;
            r_out_ccol    <= '0;
            r_out_crow    <= '0;
            r_out_last    <= 1'b1;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        r_cur_col <= n_col;
                        r_cur_row <= n_row;
                        r_kind    <= s_kind;
                        r_col     <= s_show_cell ? w_col : '0;
                        r_row     <= s_show_cell ? cr : '0;
                        r_is_cell <= s_show_cell;
                        r_last    <= !s_two;
                        r_two     <= s_two;
                        r_scroll  <= s_scroll;
                        r_addr    <= wr_addr;
                        if (s_scroll) begin
                            r_top <= (r_top == RW'(MAX_ROWS - 1)) ? '0 : r_top + RW'(1);
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (load1) begin
                        r_pend2 <= r_two;
                        r_bcol  <= '0;
                        r_state <= r_scroll ? S_BLANK : S_IDLE;
                    end
                end
                S_BLANK: begin
                    r_bcol <= r_bcol + CW'(1);
                    if (r_bcol >= last_c) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (load1) begin
                r_out_valid   <= 1'b1;
                r_out_kind    <= r_kind;
                r_out_col     <= r_col;
                r_out_row     <= r_row;
                r_out_is_cell <= r_is_cell;
                r_out_ccol    <= r_cur_col;
                r_out_crow    <= r_cur_row;
                r_out_last    <= r_last;
            end else if (load2) begin
                r_pend2       <= 1'b0;
                r_out_valid   <= 1'b1;
                r_out_kind    <= KIND_SCROLL;
                r_out_col     <= '0;
                r_out_row     <= '0;
                r_out_is_cell <= 1'b0;
                r_out_ccol    <= r_cur_col;
                r_out_crow    <= r_cur_row;
                r_out_last    <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_q_pop      = pop;
    assign o_clearing   = (r_state == S_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_col        = 7'(r_out_col);
    assign o_row        = 6'(r_out_row);
    assign o_cell_char  = r_out_is_cell ? r_rd_data : 8'd0;
    assign o_cursor_col = 7'(r_out_ccol);
    assign o_cursor_row = 6'(r_out_crow);
    assign o_last       = r_out_last;

    a_first_of_two_is_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> r_out_kind == KIND_CELL)
        else $error("non-final result is not a cell redraw");

    a_pending_follows_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend2 |-> r_out_valid && r_out_kind == KIND_CELL && !r_out_last)
        else $error("pending scroll result without its cell result");

    a_write_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> {1'b0, wr_addr} < (AW+1)'(DEPTH))
        else $error("store write outside the cell array");

    a_pop_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_state == S_EMIT && r_cur_col <= last_c)
        else $error("decoded step did not reach emit with cursor in area");

endmodule

// ===== hw/rtl/text_cell_terminal_unit.sv =====
// top level of the text cell terminal: configuration registers, front end and back end
//
// Character bytes go into a two-entry decode queue and are carried out one at a time
// against a MAX_COLS x MAX_ROWS screen store of bytes. After reset the store is filled
// with spaces by a clearing pass over all MAX_COLS*MAX_ROWS cells (8192 at the defaults),
// during which no byte is taken; configuration writes are taken at any time. Carriage
// return, line feed, backspace and ordinary bytes each go through decode and then
// result emission with the store read back. A scroll moves the top row of a row ring
// and then blanks each column in use of the new bottom row one cell per cycle through
// the single store write port. Each byte yields one result, or two when an ordinary
// byte scrolls while on screen; the cursor fields give the position after the whole byte.
module text_cell_terminal_unit import tct_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [6:0] o_col,
    output logic [5:0] o_row,
    output logic [7:0] o_cell_char,
    output logic [6:0] o_cursor_col,
    output logic [5:0] o_cursor_row,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_valid;
    t_qent q_ent;
    logic  q_pop;
    logic  clearing;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns   <= COLUMNS_RST;
            r_cfg.rows_used <= ROWS_USED_RST;
            r_cfg.on_screen <= ON_SCREEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COLUMNS:   r_cfg.columns   <= i_cfg_data;
                CFG_ROWS_USED: r_cfg.rows_used <= i_cfg_data[6:0];
                CFG_ON_SCREEN: r_cfg.on_screen <= i_cfg_data[0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    tct_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_ch      (i_ch),
        .o_ready   (o_ready),
        .i_hold    (clearing),
        .o_q_valid (q_valid),
        .o_q_ent   (q_ent),
        .i_q_pop   (q_pop)
    );

    tct_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_ent      (q_ent),
        .o_q_pop      (q_pop),
        .o_clearing   (clearing),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_col        (o_col),
        .o_row        (o_row),
        .o_cell_char  (o_cell_char),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_last       (o_last)
    );

endmodule
